FILE: src/bqr_pkg.sv
// Shared types, constants and helpers for the bulk queue with reverse.
// Used by bulk_queue_with_reverse_top and the testbench; depends on nothing.
`default_nettype none

package bqr_pkg;

  // Sizing of the run ring and of the item fields.
  localparam int unsigned RUN_SLOTS  = 1024;
  localparam int unsigned SLOT_W     = $clog2(RUN_SLOTS);
  localparam int unsigned RUNS_W     = $clog2(RUN_SLOTS + 1);
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned SIZE_W     = 25;
  localparam int unsigned SUM_W      = SIZE_W + 1;
  localparam int unsigned CAPACITY   = 16777216;
  localparam int unsigned RUN_W      = VALUE_BITS + COUNT_W;

  // Command codes on the input port.
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_REV = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DEL  = 2'b10
  } state_e;

  // Result kinds.
  localparam logic KIND_SIZE  = 1'b0;
  localparam logic KIND_FRONT = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  // One stored run: its value and how many copies it holds.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]    len;
  } run_t;

  // Ring successor of a slot.
  function automatic slot_t slot_next(slot_t s);
    slot_t r;
    if (s == slot_t'(RUN_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  // Ring predecessor of a slot.
  function automatic slot_t slot_prev(slot_t s);
    slot_t r;
    if (s == '0) begin
      r = slot_t'(RUN_SLOTS - 1);
    end else begin
      r = s - slot_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/bqr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependencies.
`default_nettype none

module bqr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/bulk_queue_with_reverse_top.sv
// Top level of the bulk queue with reverse: command decode, ring pointers, run memory.
// Depends on bqr_pkg and bqr_ram.
//
// Usage:
// - A command transaction is taken at a rising edge where start_i is high and busy_o
//   is low. command_i selects add (append value_i count_i times at the back), delete
//   (report the front, then drop count_i items) or reverse (flip the logical order).
// - Items are kept as runs (value, length) in one 1024-entry memory with a registered
//   read; a reversed flag swaps the roles of the ring's two ends.
// - Add, reverse and the unused code leave busy_o low, so a new command may follow
//   in the next cycle. An add's size report is on the result ports in the cycle
//   after acceptance.
// - A delete on an empty queue also leaves busy_o low. Otherwise busy_o is high
//   while it visits the runs (at least one), each with one memory read, until the
//   result appears.
// - Each result is shown for exactly one cycle with done_o high; the receiver
//   cannot hold it off. Reverse and the unused code give no result.
// - Reset empties the queue and clears the reversed flag; the memory needs no
//   clearing since only live runs are ever read.
`default_nettype none

module bulk_queue_with_reverse_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output      logic                                 busy_o,
  input  wire logic [1:0]                           command_i,
  input  wire logic signed [bqr_pkg::DATA_W-1:0]    value_i,
  input  wire logic [bqr_pkg::COUNT_W-1:0]          count_i,
  output      logic                                 done_o,
  output      logic                                 result_kind_o,
  output      logic [bqr_pkg::SIZE_W-1:0]           queue_size_o,
  output      logic signed [bqr_pkg::DATA_W-1:0]    front_value_o,
  output      logic                                 was_empty_o,
  output      logic                                 overflow_o
);

  // Controller and ring state.
  bqr_pkg::state_e              state_q, state_d;
  bqr_pkg::slot_t               head_q, head_d;
  bqr_pkg::slot_t               tail_q, tail_d;
  bqr_pkg::slot_t               fslot_q, fslot_d;
  logic [bqr_pkg::RUNS_W-1:0]   runs_q, runs_d;
  logic [bqr_pkg::SIZE_W-1:0]   total_q, total_d;
  logic                         rev_q, rev_d;
  logic [bqr_pkg::COUNT_W-1:0]  rem_q, rem_d;
  logic                         first_q, first_d;

  // Result registers.
  logic                         done_q, done_d;
  logic                         kind_q, kind_d;
  logic [bqr_pkg::SIZE_W-1:0]   size_q, size_d;
  logic signed [bqr_pkg::DATA_W-1:0] front_q, front_d;
  logic                         empty_q, empty_d;
  logic                         ovf_q, ovf_d;

  // Memory port signals.
  logic                         ram_we;
  bqr_pkg::slot_t               ram_waddr;
  bqr_pkg::run_t                ram_wdata;
  bqr_pkg::slot_t               ram_raddr;
  bqr_pkg::run_t                ram_rdata;

  // Helpers.
  bqr_pkg::cmd_e                cmd;
  logic                         accept;
  logic [bqr_pkg::SUM_W-1:0]    add_sum;
  bqr_pkg::slot_t               nxt_front;

  assign cmd     = bqr_pkg::cmd_e'(command_i);
  assign accept  = start_i && (state_q == bqr_pkg::ST_IDLE);
  assign add_sum = bqr_pkg::SUM_W'(total_q) + bqr_pkg::SUM_W'(count_i);
  assign nxt_front = rev_q ? bqr_pkg::slot_prev(fslot_q) : bqr_pkg::slot_next(fslot_q);

  // Run memory: value and length of each run in one word.
  bqr_ram #(
    .WIDTH(bqr_pkg::RUN_W),
    .DEPTH(bqr_pkg::RUN_SLOTS)
  ) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Command decode and delete sequencing.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fslot_d   = fslot_q;
    runs_d    = runs_q;
    total_d   = total_q;
    rev_d     = rev_q;
    rem_d     = rem_q;
    first_d   = first_q;
    done_d    = 1'b0;
    kind_d    = kind_q;
    size_d    = size_q;
    front_d   = front_q;
    empty_d   = empty_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = '{value: value_i[bqr_pkg::VALUE_BITS-1:0], len: count_i};
    ram_raddr = fslot_q;

    unique case (state_q)
      bqr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            bqr_pkg::CMD_ADD: begin
              done_d  = 1'b1;
              kind_d  = bqr_pkg::KIND_SIZE;
              empty_d = 1'b0;
              ovf_d   = 1'b0;
              front_d = '0;
              if (count_i != '0) begin
                if (runs_q == bqr_pkg::RUNS_W'(bqr_pkg::RUN_SLOTS) ||
                    add_sum > bqr_pkg::SUM_W'(bqr_pkg::CAPACITY)) begin
                  ovf_d = 1'b1;
                end else begin
                  ram_we = 1'b1;
                  if (!rev_q) begin
                    ram_waddr = tail_q;
                    tail_d    = bqr_pkg::slot_next(tail_q);
                  end else begin
                    ram_waddr = bqr_pkg::slot_prev(head_q);
                    head_d    = bqr_pkg::slot_prev(head_q);
                  end
                  runs_d  = runs_q + bqr_pkg::RUNS_W'(1);
                  total_d = add_sum[bqr_pkg::SIZE_W-1:0];
                end
              end
              size_d = total_d;
            end
            bqr_pkg::CMD_DEL: begin
              kind_d = bqr_pkg::KIND_FRONT;
              ovf_d  = 1'b0;
              if (total_q == '0 || runs_q == '0) begin
                done_d  = 1'b1;
                empty_d = 1'b1;
                size_d  = '0;
                front_d = '0;
              end else begin
                empty_d   = 1'b0;
                fslot_d   = rev_q ? bqr_pkg::slot_prev(tail_q) : head_q;
                ram_raddr = fslot_d;
                rem_d     = count_i;
                first_d   = 1'b1;
                state_d   = bqr_pkg::ST_DEL;
              end
            end
            bqr_pkg::CMD_REV: begin
              rev_d = ~rev_q;
            end
            default: begin
            end
          endcase
        end
      end

      bqr_pkg::ST_DEL: begin
        // The first run read is the front item to report.
        if (first_q) begin
          front_d = bqr_pkg::DATA_W'($signed(ram_rdata.value));
          first_d = 1'b0;
        end
        if (rem_q == '0) begin
          done_d  = 1'b1;
          size_d  = total_q;
          state_d = bqr_pkg::ST_IDLE;
        end else if (rem_q >= ram_rdata.len) begin
          // The whole front run goes; move on to the next one.
          rem_d   = rem_q - ram_rdata.len;
          total_d = total_q - bqr_pkg::SIZE_W'(ram_rdata.len);
          runs_d  = runs_q - bqr_pkg::RUNS_W'(1);
          if (!rev_q) begin
            head_d = bqr_pkg::slot_next(head_q);
          end else begin
            tail_d = bqr_pkg::slot_prev(tail_q);
          end
          fslot_d   = nxt_front;
          ram_raddr = nxt_front;
          if (rem_d == '0 || runs_d == '0) begin
            done_d  = 1'b1;
            size_d  = total_d;
            state_d = bqr_pkg::ST_IDLE;
          end
        end else begin
          // Trim the front run and write its new length back.
          ram_we    = 1'b1;
          ram_waddr = fslot_q;
          ram_wdata = '{value: ram_rdata.value, len: ram_rdata.len - rem_q};
          total_d   = total_q - bqr_pkg::SIZE_W'(rem_q);
          rem_d     = '0;
          done_d    = 1'b1;
          size_d    = total_d;
          state_d   = bqr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bqr_pkg::ST_IDLE;
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqr_pkg::ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      fslot_q <= '0;
      runs_q  <= '0;
      total_q <= '0;
      rev_q   <= 1'b0;
      rem_q   <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      kind_q  <= 1'b0;
      size_q  <= '0;
      front_q <= '0;
      empty_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fslot_q <= fslot_d;
      runs_q  <= runs_d;
      total_q <= total_d;
      rev_q   <= rev_d;
      rem_q   <= rem_d;
      first_q <= first_d;
      done_q  <= done_d;
      kind_q  <= kind_d;
      size_q  <= size_d;
      front_q <= front_d;
      empty_q <= empty_d;
      ovf_q   <= ovf_d;
    end
  end

  // Outputs.
  assign busy_o        = (state_q != bqr_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign result_kind_o = kind_q;
  assign queue_size_o  = size_q;
  assign front_value_o = front_q;
  assign was_empty_o   = empty_q;
  assign overflow_o    = ovf_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for bulk_queue_with_reverse_top. Commands are driven with
// random sender gaps, and every result is checked against a run-ring queue predictor.
// Depends on bqr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  // One result transaction as seen on the result ports.
  typedef struct packed {
    logic                       kind;
    logic [bqr_pkg::SIZE_W-1:0] size;
    logic [bqr_pkg::DATA_W-1:0] front;
    logic                       empty;
    logic                       ovf;
  } queue_report_t;

  // Scoreboard: predicts the queue from accepted commands and checks each result.
  class queue_scoreboard;
    logic [bqr_pkg::DATA_W-1:0]  run_value [bqr_pkg::RUN_SLOTS];
    logic [bqr_pkg::COUNT_W-1:0] run_len [bqr_pkg::RUN_SLOTS];
    int unsigned        head_pos;
    int unsigned        tail_pos;
    int unsigned        live_runs;
    longint unsigned    item_total;
    bit                 reversed;
    queue_report_t      expected_q[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        commands;
    int unsigned        overflows;
    int unsigned        empty_dels;

    function new();
      head_pos   = 0;
      tail_pos   = 0;
      live_runs  = 0;
      item_total = 0;
      reversed   = 1'b0;
      errors     = 0;
      checked    = 0;
      commands   = 0;
      overflows  = 0;
      empty_dels = 0;
    endfunction

    function int unsigned wrap_up(int unsigned p);
      return (p + 1 >= bqr_pkg::RUN_SLOTS) ? 0 : p + 1;
    endfunction

    function int unsigned wrap_down(int unsigned p);
      return (p == 0) ? bqr_pkg::RUN_SLOTS - 1 : p - 1;
    endfunction

    // The logical front is the last physical run while the order is flipped.
    function int unsigned front_pos();
      return reversed ? wrap_down(tail_pos) : head_pos;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command to the predicted queue and note its result.
    function void note_command(bqr_pkg::cmd_e cmd, logic [bqr_pkg::DATA_W-1:0] val,
                               logic [bqr_pkg::COUNT_W-1:0] cnt);
      queue_report_t   rep;
      int unsigned     pos;
      longint unsigned left;
      rep = '0;
      commands++;
      case (cmd)
        bqr_pkg::CMD_REV: begin
          reversed = !reversed;
        end
        bqr_pkg::CMD_ADD: begin
          rep.kind = bqr_pkg::KIND_SIZE;
          if (cnt != '0) begin
            if (live_runs >= bqr_pkg::RUN_SLOTS || item_total + cnt > bqr_pkg::CAPACITY) begin
              rep.ovf = 1'b1;
              overflows++;
            end else begin
              if (!reversed) begin
                pos      = tail_pos;
                tail_pos = wrap_up(tail_pos);
              end else begin
                head_pos = wrap_down(head_pos);
                pos      = head_pos;
              end
              run_value[pos] = val;
              run_len[pos]   = cnt;
              live_runs++;
              item_total += cnt;
            end
          end
          rep.size = item_total[bqr_pkg::SIZE_W-1:0];
          expected_q.push_back(rep);
        end
        bqr_pkg::CMD_DEL: begin
          rep.kind = bqr_pkg::KIND_FRONT;
          if (item_total == 0) begin
            rep.empty = 1'b1;
            empty_dels++;
          end else begin
            rep.front = run_value[front_pos()];
            left = cnt;
            // Whole runs go first; the last one touched may only shrink.
            while (left > 0 && live_runs > 0) begin
              pos = front_pos();
              if (left >= run_len[pos]) begin
                left       -= run_len[pos];
                item_total -= run_len[pos];
                live_runs--;
                if (!reversed) begin
                  head_pos = wrap_up(head_pos);
                end else begin
                  tail_pos = wrap_down(tail_pos);
                end
              end else begin
                run_len[pos] = run_len[pos] - bqr_pkg::COUNT_W'(left);
                item_total  -= left;
                left         = 0;
              end
            end
            rep.size = item_total[bqr_pkg::SIZE_W-1:0];
          end
          expected_q.push_back(rep);
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(queue_report_t got);
      queue_report_t want;
      if (expected_q.size() == 0) begin
        $error("result with no command waiting: kind %0d, queue_size %0d", got.kind, got.size);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.size !== want.size) begin
        $error("queue_size: expected %0d, got %0d", want.size, got.size);
        errors++;
      end
      if (got.front !== want.front) begin
        $error("front_value: expected %0d, got %0d", $signed(want.front), $signed(got.front));
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("was_empty: expected %0d, got %0d", want.empty, got.empty);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic [1:0]                         command_i = bqr_pkg::CMD_NOP;
  logic signed [bqr_pkg::DATA_W-1:0]  value_i = '0;
  logic [bqr_pkg::COUNT_W-1:0]        count_i = '0;
  logic                               busy_o;
  logic                               done_o;
  logic                               result_kind_o;
  logic [bqr_pkg::SIZE_W-1:0]         queue_size_o;
  logic signed [bqr_pkg::DATA_W-1:0]  front_value_o;
  logic                               was_empty_o;
  logic                               overflow_o;

  queue_scoreboard sb = new();
  int unsigned     idle_pct = 0;

  bulk_queue_with_reverse_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .count_i       (count_i),
    .done_o        (done_o),
    .result_kind_o (result_kind_o),
    .queue_size_o  (queue_size_o),
    .front_value_o (front_value_o),
    .was_empty_o   (was_empty_o),
    .overflow_o    (overflow_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #4_000_000;
    $display("[bulk_queue_with_reverse_top] ERROR");
    $finish;
  end

  // Monitor: results are checked before the command taken at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result({result_kind_o, queue_size_o, front_value_o, was_empty_o, overflow_o});
      end
      if (start_i && !busy_o) begin
        sb.note_command(bqr_pkg::cmd_e'(command_i), value_i, count_i);
      end
    end
  end

  // Present one command and hold it until the block takes it, then maybe idle.
  // Each further idle cycle is drawn with the same chance, so idle_pct is the
  // share of sender cycles spent idle.
  task automatic issue(bqr_pkg::cmd_e cmd, logic [bqr_pkg::DATA_W-1:0] val,
                       logic [bqr_pkg::COUNT_W-1:0] cnt);
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    count_i   <= cnt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  // Stop sending until every predicted result has come back.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One random command; the unused code does not count as real work.
  task automatic random_command(output bit useful);
    int unsigned                 pick;
    int unsigned                 sz;
    logic [bqr_pkg::DATA_W-1:0]  val;
    logic [bqr_pkg::COUNT_W-1:0] cnt;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      default: val = $urandom();
    endcase
    // Mostly short runs, now and then a huge one that hits the capacity limit.
    sz = $urandom_range(99);
    if (sz < 10) begin
      cnt = '0;
    end else if (sz < 80) begin
      cnt = bqr_pkg::COUNT_W'($urandom_range(1, 16));
    end else if (sz < 95) begin
      cnt = bqr_pkg::COUNT_W'($urandom_range(17, 4096));
    end else if (sz < 98) begin
      cnt = bqr_pkg::COUNT_W'($urandom());
    end else begin
      cnt = '1;
    end
    useful = 1'b1;
    if (pick < 45) begin
      issue(bqr_pkg::CMD_ADD, val, cnt);
    end else if (pick < 82) begin
      issue(bqr_pkg::CMD_DEL, val, cnt);
    end else if (pick < 94) begin
      issue(bqr_pkg::CMD_REV, val, cnt);
    end else begin
      issue(bqr_pkg::CMD_NOP, val, cnt);
      useful = 1'b0;
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned sent;
    bit          useful;
    sent = 0;
    while (sent < n) begin
      random_command(useful);
      if (useful) begin
        sent++;
      end
      if ($urandom_range(59) == 0) begin
        settle();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, zero counts, extremes, partial and full deletes, capacity.
    issue(bqr_pkg::CMD_DEL, 32'h1234_5678, '0);
    issue(bqr_pkg::CMD_DEL, '1, 24'd5);
    issue(bqr_pkg::CMD_REV, '0, '0);
    issue(bqr_pkg::CMD_REV, '0, '0);
    issue(bqr_pkg::CMD_ADD, 32'h7FFF_FFFF, '0);
    issue(bqr_pkg::CMD_ADD, 32'h8000_0000, 24'd1);
    issue(bqr_pkg::CMD_ADD, 32'h7FFF_FFFF, 24'd2);
    issue(bqr_pkg::CMD_ADD, '1, 24'd3);
    issue(bqr_pkg::CMD_ADD, '1, 24'd1);
    issue(bqr_pkg::CMD_DEL, '0, '0);
    issue(bqr_pkg::CMD_REV, '0, '0);
    issue(bqr_pkg::CMD_DEL, '0, 24'd2);
    issue(bqr_pkg::CMD_NOP, '1, '1);
    issue(bqr_pkg::CMD_ADD, 32'h0000_002A, 24'd2);
    issue(bqr_pkg::CMD_DEL, '0, 24'd1);
    issue(bqr_pkg::CMD_REV, '0, '0);
    issue(bqr_pkg::CMD_DEL, '0, '1);
    issue(bqr_pkg::CMD_ADD, 32'h0000_0001, '1);
    issue(bqr_pkg::CMD_ADD, 32'h0000_0002, 24'd1);
    issue(bqr_pkg::CMD_ADD, 32'h0000_0003, 24'd1);
    issue(bqr_pkg::CMD_ADD, 32'h0000_0004, '0);
    issue(bqr_pkg::CMD_REV, '0, '0);
    issue(bqr_pkg::CMD_DEL, '0, '0);
    issue(bqr_pkg::CMD_DEL, '0, '1);
    settle();

    // Random traffic under three sender gap profiles.
    idle_pct = 13;
    random_phase(25);
    settle();
    idle_pct = 47;
    random_phase(25);
    settle();
    idle_pct = 0;

    // Fill every run slot, with reversals mixed in, then push past the slot limit.
    issue(bqr_pkg::CMD_DEL, $urandom(), '1);
    repeat (bqr_pkg::RUN_SLOTS + 4) begin
      if ($urandom_range(63) == 0) begin
        issue(bqr_pkg::CMD_REV, $urandom(), bqr_pkg::COUNT_W'($urandom()));
      end
      issue(bqr_pkg::CMD_ADD, $urandom(), bqr_pkg::COUNT_W'($urandom_range(1, 3)));
    end
    issue(bqr_pkg::CMD_DEL, $urandom(), 24'd5);
    issue(bqr_pkg::CMD_ADD, $urandom(), 24'd2);
    issue(bqr_pkg::CMD_REV, $urandom(), '0);
    issue(bqr_pkg::CMD_DEL, $urandom(), '1);
    settle();

    random_phase(25);
    settle();
    repeat (16) @(posedge clk_i);

    $display("Checked %0d results from %0d commands: %0d dropped adds, %0d empty deletes.",
             sb.checked, sb.commands, sb.overflows, sb.empty_dels);
    $display("Sender gaps of 13 and 47 percent, then back to back; all %0d run slots filled.",
             bqr_pkg::RUN_SLOTS);
    if (sb.errors == 0) begin
      $display("[bulk_queue_with_reverse_top] OK");
    end else begin
      $display("[bulk_queue_with_reverse_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bqr_pkg.sv
src/bqr_ram.sv
src/bulk_queue_with_reverse_top.sv
tb/testbench.sv
